// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion shorthands; every use samples on clk_i and is disabled
// while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every sampled clock edge.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that implies a consequence in the same cycle.
`define ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A condition that implies a consequence in the next cycle.
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ffcq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-fit capacity queue package
// Shared types, codes and defaults for the first-fit capacity queue.
// ----------------------------------------------------------------------------
package ffcq_pkg;

  // Default number of queue entries.
  localparam int QUEUE_DEPTH = 16;

  // Request action codes.
  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_SERVICE = 2'd1,
    ACT_LIST    = 2'd2
  } action_e;

  // Result status codes.
  typedef enum logic [2:0] {
    STATUS_ACCEPTED = 3'd0,
    STATUS_FULL     = 3'd1,
    STATUS_SERVED   = 3'd2,
    STATUS_NONE     = 3'd3,
    STATUS_LISTED   = 3'd4,
    STATUS_EMPTY    = 3'd5
  } status_e;

  // Input item.
  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] tag;
    logic [7:0]  request_size;
    logic [7:0]  capacity;
  } req_t;

  // Result item.
  typedef struct packed {
    status_e     status;
    logic [15:0] out_tag;
    logic [7:0]  out_size;
    logic [4:0]  position;
    logic [7:0]  capacity_left;
    logic        last;
  } rsp_t;

  // One stored queue entry.
  typedef struct packed {
    logic [15:0] tag;
    logic [7:0]  size;
  } entry_t;

  // Outcome of one fit check.
  typedef struct packed {
    logic       fits;
    logic [7:0] left;
  } fit_res_t;

endpackage

// File: hdl/ffcq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with a registered read.
// ----------------------------------------------------------------------------
module ffcq_ram #(
  parameter int Width = 24,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/ffcq_fit_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fit unit
// Shared subtract-and-compare that checks one entry size against the
// remaining capacity.
// ----------------------------------------------------------------------------
module ffcq_fit_unit (
  input  logic [7:0]         left_i,
  input  logic [7:0]         size_i,
  output ffcq_pkg::fit_res_t res_o
);

  logic [8:0] diff;

  // A borrow out of the subtraction means the entry does not fit.
  assign diff       = {1'b0, left_i} - {1'b0, size_i};
  assign res_o.fits = ~diff[8];
  assign res_o.left = diff[7:0];

endmodule

// File: hdl/first_fit_capacity_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-fit capacity queue
// Ordered request queue serviced first-fit against a granted capacity.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on in_i with in_valid_i/in_ready_o; results leave on out_o
// with out_valid_o/out_ready_i. A transfer happens when valid and ready are
// both high. Each request yields one or more results, the final one marked
// by out_o.last; action code 3 is dropped with no result.
// The block takes one request at a time and is ready only when idle.
// An insert, or a service or list of an empty queue, goes from its transfer
// into the holding register and then into the output register. A service or
// list walks the stored entries through one RAM read port and one shared fit
// unit, in a read state and then an evaluate state for each entry.
// Results pass through a one-deep holding register and an output register;
// while the receiver stalls, the walk pauses at the next entry that yields
// a result. The final result sits in the output register while the next
// request is accepted.
// Reset clears the entry count and all handshake state; RAM contents are
// not cleared and need not be, since only entries below the count are read.
// ----------------------------------------------------------------------------
module first_fit_capacity_queue_unit #(
  parameter int QueueDepth = ffcq_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ffcq_pkg::req_t in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ffcq_pkg::rsp_t out_o
);

  `include "assert_macros.svh"

  localparam int AW = $clog2(QueueDepth);
  localparam int CW = $clog2(QueueDepth + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_EVAL  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_e;

  state_e                  state_q, state_d;
  logic [CW-1:0]           count_q, count_d;
  logic [CW-1:0]           idx_q, idx_d;
  logic [CW-1:0]           idx_next;
  logic [CW-1:0]           keep_q, keep_d;
  logic [7:0]              left_q, left_d;
  logic [7:0]              cap_q, cap_d;
  logic                    list_q, list_d;
  logic                    served_q, served_d;
  logic                    pend_valid_q, pend_valid_d;
  ffcq_pkg::rsp_t          pend_q, pend_d;
  logic                    out_valid_q, out_valid_d;
  ffcq_pkg::rsp_t          out_q, out_d;
  logic                    out_free;
  logic                    emit;
  logic [31:0]             pos_wide;
  ffcq_pkg::rsp_t          walk_res;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  ffcq_pkg::entry_t        ram_wdata;
  logic                    ram_re;
  ffcq_pkg::entry_t        ram_rdata;
  ffcq_pkg::fit_res_t      fit;

  // Entry storage.
  ffcq_ram #(
    .Width ($bits(ffcq_pkg::entry_t)),
    .Depth (QueueDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Shared fit check against the remaining capacity.
  ffcq_fit_unit u_fit (
    .left_i (left_q),
    .size_i (ram_rdata.size),
    .res_o  (fit)
  );

  // Result produced by the entry currently under evaluation.
  assign idx_next = idx_q + CW'(1);
  assign pos_wide = 32'(idx_q) + 32'd1;
  assign emit     = list_q | fit.fits;
  assign out_free = ~out_valid_q | out_ready_i;

  always_comb begin
    walk_res               = '0;
    walk_res.status        = list_q ? ffcq_pkg::STATUS_LISTED : ffcq_pkg::STATUS_SERVED;
    walk_res.out_tag       = ram_rdata.tag;
    walk_res.out_size      = ram_rdata.size;
    walk_res.position      = list_q ? pos_wide[4:0] : 5'd0;
    walk_res.capacity_left = list_q ? 8'd0 : fit.left;
  end

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    keep_d       = keep_q;
    left_d       = left_q;
    cap_d        = cap_q;
    list_d       = list_q;
    served_d     = served_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    out_d        = out_q;
    ram_we       = 1'b0;
    ram_waddr    = count_q[AW-1:0];
    ram_wdata    = {in_i.tag, in_i.request_size};
    ram_re       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_i.action)
            ffcq_pkg::ACT_INSERT: begin
              pend_valid_d = 1'b1;
              pend_d       = '0;
              if (count_q < CW'(QueueDepth)) begin
                ram_we        = 1'b1;
                count_d       = count_q + CW'(1);
                pend_d.status = ffcq_pkg::STATUS_ACCEPTED;
              end else begin
                pend_d.status = ffcq_pkg::STATUS_FULL;
              end
              state_d = ST_FLUSH;
            end
            ffcq_pkg::ACT_SERVICE, ffcq_pkg::ACT_LIST: begin
              if (count_q == '0) begin
                pend_valid_d  = 1'b1;
                pend_d        = '0;
                pend_d.status = ffcq_pkg::STATUS_EMPTY;
                state_d       = ST_FLUSH;
              end else begin
                idx_d    = '0;
                keep_d   = '0;
                left_d   = in_i.capacity;
                cap_d    = in_i.capacity;
                list_d   = (in_i.action == ffcq_pkg::ACT_LIST);
                served_d = 1'b0;
                state_d  = ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_READ: begin
        ram_re  = 1'b1;
        state_d = ST_EVAL;
      end

      ST_EVAL: begin
        // Pause while a new result has nowhere to go.
        if (!(emit && pend_valid_q && !out_free)) begin
          if (emit && pend_valid_q) begin
            out_valid_d = 1'b1;
            out_d       = pend_q;
          end
          if (emit) begin
            pend_valid_d = 1'b1;
            pend_d       = walk_res;
          end
          // Service: consume fitting entries, compact the rest toward the head.
          if (!list_q) begin
            if (fit.fits) begin
              left_d   = fit.left;
              served_d = 1'b1;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = keep_q[AW-1:0];
              ram_wdata = ram_rdata;
              keep_d    = keep_q + CW'(1);
            end
          end
          idx_d = idx_next;
          if (idx_next == count_q) begin
            state_d = ST_FLUSH;
            if (!list_q) begin
              count_d = keep_d;
              if (!fit.fits && !served_q) begin
                pend_valid_d         = 1'b1;
                pend_d               = '0;
                pend_d.status        = ffcq_pkg::STATUS_NONE;
                pend_d.capacity_left = cap_q;
              end
            end
          end else begin
            state_d = ST_READ;
          end
        end
      end

      ST_FLUSH: begin
        // Final result of the request goes out marked last.
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_d        = pend_q;
          out_d.last   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      idx_q        <= '0;
      keep_q       <= '0;
      list_q       <= 1'b0;
      served_q     <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      idx_q        <= idx_d;
      keep_q       <= keep_d;
      list_q       <= list_d;
      served_q     <= served_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    left_q <= left_d;
    cap_q  <= cap_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Checks.
  `ASSERT_ALWAYS(a_count_bound, count_q <= CW'(QueueDepth), "entry count exceeds queue depth")
  `ASSERT_IMPLIES(a_idle_no_pend, in_ready_o, !pend_valid_q, "holding register busy while idle")
  `ASSERT_IMPLIES(a_flush_has_pend, state_q == ST_FLUSH, pend_valid_q, "flush without a result")
  `ASSERT_NEXT(a_flush_last, (state_q == ST_FLUSH) && (state_d == ST_IDLE),
               out_valid_q && out_q.last, "final result not marked last")

endmodule
